>>> src/ps2mt_pkg.sv
package ps2mt_pkg;

  // Field widths
  localparam int BYTE_W  = 8;
  localparam int POS_W   = 12;
  localparam int SENS_W  = 5;
  localparam int SIZE_W  = 13;
  localparam int INDEX_W = 2;
  localparam int DATA_W  = 13;
  localparam int BTN_W   = 3;

  // Status and header bit positions
  localparam int STATUS_READY_BIT = 0;
  localparam int STATUS_AUX_BIT   = 5;
  localparam int HDR_SYNC_BIT     = 3;
  localparam int BTN_LEFT_BIT     = 0;
  localparam int BTN_RIGHT_BIT    = 1;
  localparam int BTN_MIDDLE_BIT   = 2;

  // Register indexes
  localparam logic [INDEX_W-1:0] REG_SENSITIVITY   = 2'd0;
  localparam logic [INDEX_W-1:0] REG_SCREEN_WIDTH  = 2'd1;
  localparam logic [INDEX_W-1:0] REG_SCREEN_HEIGHT = 2'd2;

  // Register reset values
  localparam logic [SENS_W-1:0] SENS_RESET   = 5'd2;
  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd1024;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd768;
  localparam logic [SIZE_W-1:0] SIZE_LIMIT   = 13'd4096;

  // Byte positions within a packet
  localparam logic [1:0] POS_HEADER = 2'd0;
  localparam logic [1:0] POS_X      = 2'd1;
  localparam logic [1:0] POS_Y      = 2'd2;

  // Scale a signed movement byte by sensitivity / 2, truncating toward zero
  function automatic logic signed [12:0] scale_delta(input logic [BYTE_W-1:0] b,
                                                     input logic [SENS_W-1:0] sens);
    logic signed [13:0] prod;
    logic signed [13:0] adj;
    logic signed [13:0] half;
    prod = $signed(b) * $signed({1'b0, sens});
    adj  = prod + $signed({13'd0, prod[13]});
    half = adj >>> 1;
    return half[12:0];
  endfunction

  // Saturate a position to [0, size - 1], with size held to [1, 4096]
  function automatic logic [POS_W-1:0] clamp_axis(input logic signed [14:0] v,
                                                  input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] lim;
    logic [POS_W-1:0]  top;
    if (size == '0) lim = 13'd1;
    else if (size > SIZE_LIMIT) lim = SIZE_LIMIT;
    else lim = size;
    top = POS_W'(lim - 13'd1);
    if (v < 0) return '0;
    else if (v > $signed({3'b000, top})) return top;
    else return v[POS_W-1:0];
  endfunction

endpackage

>>> src/ps2mt_if.sv
interface ps2mt_in_if
  import ps2mt_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] ctrl_status;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output ctrl_status, output data_byte, input ready);
  modport sink   (input valid, input ctrl_status, input data_byte, output ready);
endinterface

interface ps2mt_out_if
  import ps2mt_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] cursor_x;
  logic [POS_W-1:0] cursor_y;
  logic             left_down;
  logic             right_down;
  logic             middle_down;
  logic             left_press;
  logic             right_press;
  logic             left_rel;
  logic             right_rel;

  modport source (output valid, output cursor_x, output cursor_y, output left_down,
                  output right_down, output middle_down, output left_press,
                  output right_press, output left_rel, output right_rel,
                  input ready);
  modport sink   (input valid, input cursor_x, input cursor_y, input left_down,
                  input right_down, input middle_down, input left_press,
                  input right_press, input left_rel, input right_rel,
                  output ready);
endinterface

>>> src/ps2_mouse_packet_tracker.sv
// PS/2 mouse packet tracker.
// The bytes channel carries one controller status byte and one data byte per
// transfer. Bytes whose status lacks data-ready or auxiliary bits are ignored;
// the rest are gathered into three-byte packets. Each packet with the sync bit
// set in its header yields one transfer on the results channel with the
// saturated cursor position, button levels and per-packet press/release edges.
// Packets without the sync bit are dropped silently.
// A byte is held in the input register while it is decoded; the result of a
// packet's last byte is loaded from there into the result register, from which
// it transfers when the receiver is ready.
// Throughput: one byte per cycle while the receiver keeps ready high.
// When the receiver stalls, the result register holds; the input register takes
// one more byte if it is empty, then ready stays low until the result is taken.
// The write port sets sensitivity, screen width and screen height; write it
// only while the block is idle. Reset restores the register defaults, homes the
// cursor at the origin, releases all buttons and restarts packet alignment.
module ps2_mouse_packet_tracker
  import ps2mt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  ps2mt_in_if.sink           bytes,
  ps2mt_out_if.source        results,
  input  logic               wr_en,
  input  logic [INDEX_W-1:0] wr_index,
  input  logic [DATA_W-1:0]  wr_data
);

  // Configuration registers
  logic [SENS_W-1:0] sensitivity;
  logic [SIZE_W-1:0] screen_width;
  logic [SIZE_W-1:0] screen_height;

  // Input register
  logic              s1_valid;
  logic [BYTE_W-1:0] s1_status;
  logic [BYTE_W-1:0] s1_data;

  // Tracker state
  logic [1:0]        byte_pos;
  logic [BYTE_W-1:0] held_hdr;
  logic [BYTE_W-1:0] held_x;
  logic [POS_W-1:0]  pos_x;
  logic [POS_W-1:0]  pos_y;
  logic [BTN_W-1:0]  btn;

  // Result register
  logic out_valid;

  logic               advance;
  logic               take;
  logic               complete;
  logic               good;
  logic signed [12:0] dx;
  logic signed [12:0] dy;
  logic signed [14:0] vx;
  logic signed [14:0] vy;
  logic [POS_W-1:0]   pos_x_next;
  logic [POS_W-1:0]   pos_y_next;
  logic [BTN_W-1:0]   btn_next;

  // Move the input register forward whenever the result register can take it
  assign advance       = !out_valid || results.ready;
  assign bytes.ready   = !s1_valid || advance;
  assign results.valid = out_valid;

  // Decode the held byte and compute the new cursor
  always_comb begin
    take       = s1_valid && advance && s1_status[STATUS_READY_BIT]
                 && s1_status[STATUS_AUX_BIT];
    complete   = take && (byte_pos == POS_Y);
    good       = complete && held_hdr[HDR_SYNC_BIT];
    dx         = scale_delta(held_x, sensitivity);
    dy         = scale_delta(s1_data, sensitivity);
    vx         = $signed({3'b000, pos_x}) + 15'(dx);
    vy         = $signed({3'b000, pos_y}) - 15'(dy);
    pos_x_next = clamp_axis(vx, screen_width);
    pos_y_next = clamp_axis(vy, screen_height);
    btn_next   = held_hdr[BTN_W-1:0];
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sensitivity   <= SENS_RESET;
      screen_width  <= WIDTH_RESET;
      screen_height <= HEIGHT_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_SENSITIVITY:   sensitivity   <= wr_data[SENS_W-1:0];
        REG_SCREEN_WIDTH:  screen_width  <= wr_data[SIZE_W-1:0];
        REG_SCREEN_HEIGHT: screen_height <= wr_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (bytes.ready) begin
      s1_valid <= bytes.valid;
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      s1_status <= bytes.ctrl_status;
      s1_data   <= bytes.data_byte;
    end
  end

  // Packet alignment and tracker state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos <= POS_HEADER;
      pos_x    <= '0;
      pos_y    <= '0;
      btn      <= '0;
    end else if (take) begin
      if (complete) byte_pos <= POS_HEADER;
      else byte_pos <= byte_pos + 2'd1;
      if (good) begin
        pos_x <= pos_x_next;
        pos_y <= pos_y_next;
        btn   <= btn_next;
      end
    end
  end

  // Hold the first two bytes of a packet
  always_ff @(posedge clk) begin
    if (take && byte_pos == POS_HEADER) held_hdr <= s1_data;
    if (take && byte_pos == POS_X) held_x <= s1_data;
  end

  // Result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= good;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (good) begin
      results.cursor_x    <= pos_x_next;
      results.cursor_y    <= pos_y_next;
      results.left_down   <= btn_next[BTN_LEFT_BIT];
      results.right_down  <= btn_next[BTN_RIGHT_BIT];
      results.middle_down <= btn_next[BTN_MIDDLE_BIT];
      results.left_press  <= btn_next[BTN_LEFT_BIT] && !btn[BTN_LEFT_BIT];
      results.right_press <= btn_next[BTN_RIGHT_BIT] && !btn[BTN_RIGHT_BIT];
      results.left_rel    <= !btn_next[BTN_LEFT_BIT] && btn[BTN_LEFT_BIT];
      results.right_rel   <= !btn_next[BTN_RIGHT_BIT] && btn[BTN_RIGHT_BIT];
    end
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ps2mt_pkg::*;

  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 4;
  localparam int PACKETS_PER_PHASE = 130;

  localparam logic [BYTE_W-1:0] READY_AUX_MASK =
    (8'd1 << STATUS_READY_BIT) | (8'd1 << STATUS_AUX_BIT);

  typedef struct packed {
    logic [POS_W-1:0] cursor_x;
    logic [POS_W-1:0] cursor_y;
    logic             left_down;
    logic             right_down;
    logic             middle_down;
    logic             left_press;
    logic             right_press;
    logic             left_rel;
    logic             right_rel;
  } mouse_report_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               wr_en;
  logic [INDEX_W-1:0] wr_index;
  logic [DATA_W-1:0]  wr_data;

  ps2mt_in_if  in_ch ();
  ps2mt_out_if out_ch ();

  ps2_mouse_packet_tracker i_dut (
    .clk      (clk),
    .rst      (rst),
    .bytes    (in_ch),
    .results  (out_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  // Tracker state mirrored by the testbench
  logic [SENS_W-1:0] cfg_sens   = SENS_RESET;
  logic [SIZE_W-1:0] cfg_width  = WIDTH_RESET;
  logic [SIZE_W-1:0] cfg_height = HEIGHT_RESET;
  logic [1:0]        pkt_pos    = POS_HEADER;
  logic [BYTE_W-1:0] hdr_held   = '0;
  logic [BYTE_W-1:0] x_held     = '0;
  logic [POS_W-1:0]  cur_x      = '0;
  logic [POS_W-1:0]  cur_y      = '0;
  logic [BTN_W-1:0]  btn_prev   = '0;

  mouse_report_t pending_reports[$];
  mouse_report_t want_rpt;

  int  error_count = 0;
  int  stall_left  = 0;
  int  quiet_cycles = 0;
  bit  idling = 1'b1;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Saturate a signed position to [0, size - 1], with size held to [1, 4096]
  function automatic logic [POS_W-1:0] saturate(input int v, input logic [SIZE_W-1:0] size);
    int top;
    if (size == '0) top = 0;
    else if (size > SIZE_LIMIT) top = int'(SIZE_LIMIT) - 1;
    else top = int'(size) - 1;
    if (v < 0) return '0;
    if (v > top) return POS_W'(top);
    return POS_W'(v);
  endfunction

  // Advance the mirrored tracker by one transferred byte; queue a report if a packet lands
  task automatic track_byte(input logic [BYTE_W-1:0] status, input logic [BYTE_W-1:0] data);
    int               dx;
    int               dy;
    logic [BTN_W-1:0] btn_now;
    mouse_report_t    rpt;
    if (!(status[STATUS_READY_BIT] && status[STATUS_AUX_BIT])) return;
    if (pkt_pos == POS_HEADER) begin
      hdr_held = data;
      pkt_pos  = POS_X;
      return;
    end
    if (pkt_pos == POS_X) begin
      x_held  = data;
      pkt_pos = POS_Y;
      return;
    end
    pkt_pos = POS_HEADER;
    // Drop packets that lost sync
    if (!hdr_held[HDR_SYNC_BIT]) return;
    dx = $signed(x_held);
    dx = dx * int'(cfg_sens) / 2;
    dy = $signed(data);
    dy = dy * int'(cfg_sens) / 2;
    cur_x = saturate(int'(cur_x) + dx, cfg_width);
    cur_y = saturate(int'(cur_y) - dy, cfg_height);
    btn_now = hdr_held[BTN_W-1:0];
    rpt.cursor_x    = cur_x;
    rpt.cursor_y    = cur_y;
    rpt.left_down   = btn_now[BTN_LEFT_BIT];
    rpt.right_down  = btn_now[BTN_RIGHT_BIT];
    rpt.middle_down = btn_now[BTN_MIDDLE_BIT];
    rpt.left_press  = btn_now[BTN_LEFT_BIT] & ~btn_prev[BTN_LEFT_BIT];
    rpt.right_press = btn_now[BTN_RIGHT_BIT] & ~btn_prev[BTN_RIGHT_BIT];
    rpt.left_rel    = ~btn_now[BTN_LEFT_BIT] & btn_prev[BTN_LEFT_BIT];
    rpt.right_rel   = ~btn_now[BTN_RIGHT_BIT] & btn_prev[BTN_RIGHT_BIT];
    btn_prev = btn_now;
    pending_reports.push_back(rpt);
  endtask

  // Drive one byte and hold it until the transfer completes
  task automatic send_byte(input logic [BYTE_W-1:0] status, input logic [BYTE_W-1:0] data);
    if (idling && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.ctrl_status <= status;
    in_ch.data_byte   <= data;
    do @(posedge clk); while (!in_ch.ready);
    track_byte(status, data);
  endtask

  function automatic logic [BYTE_W-1:0] taken_status();
    return BYTE_W'($urandom_range(0, 255)) | READY_AUX_MASK;
  endfunction

  function automatic logic [BYTE_W-1:0] ignored_status();
    logic [BYTE_W-1:0] s;
    s = BYTE_W'($urandom_range(0, 255));
    case ($urandom_range(0, 2))
      0: s[STATUS_READY_BIT] = 1'b0;
      1: s[STATUS_AUX_BIT] = 1'b0;
      default: begin
        s[STATUS_READY_BIT] = 1'b0;
        s[STATUS_AUX_BIT]   = 1'b0;
      end
    endcase
    return s;
  endfunction

  task automatic send_packet(input logic [BYTE_W-1:0] hdr, input logic [BYTE_W-1:0] dx,
                             input logic [BYTE_W-1:0] dy);
    send_byte(taken_status(), hdr);
    send_byte(taken_status(), dx);
    send_byte(taken_status(), dy);
  endtask

  function automatic logic [BYTE_W-1:0] random_delta();
    if ($urandom_range(0, 1)) return BYTE_W'($urandom_range(0, 255));
    return BYTE_W'($urandom_range(0, 16) - 8);
  endfunction

  // Mostly well-formed packets; some noise, stray ignored bytes and unsynced headers
  task automatic send_random_packet();
    int                r;
    logic [BYTE_W-1:0] hdr;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      send_byte(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
      return;
    end
    hdr = BYTE_W'($urandom_range(0, 255));
    if (r >= 15) hdr[HDR_SYNC_BIT] = 1'b1;
    send_byte(taken_status(), hdr);
    if (r % 10 == 0) send_byte(ignored_status(), BYTE_W'($urandom_range(0, 255)));
    send_byte(taken_status(), random_delta());
    send_byte(taken_status(), random_delta());
  endtask

  // Write all three registers, one per cycle
  task automatic apply_settings(input logic [DATA_W-1:0] sens, input logic [DATA_W-1:0] width,
                                input logic [DATA_W-1:0] height);
    wr_en    <= 1'b1;
    wr_index <= REG_SENSITIVITY;
    wr_data  <= sens;
    @(posedge clk);
    wr_index <= REG_SCREEN_WIDTH;
    wr_data  <= width;
    @(posedge clk);
    wr_index <= REG_SCREEN_HEIGHT;
    wr_data  <= height;
    @(posedge clk);
    wr_en <= 1'b0;
    cfg_sens   = sens[SENS_W-1:0];
    cfg_width  = width[SIZE_W-1:0];
    cfg_height = height[SIZE_W-1:0];
  endtask

  // Hold off until every queued report has arrived and the pipeline is empty
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Default registers: ignored bytes, button edges, dropped packet, axis extremes
  task automatic test_packet_basics();
    send_byte(8'h00, 8'hFF);
    send_byte(8'h01, 8'h08);
    send_byte(8'h20, 8'h08);
    send_byte(8'hDE, 8'hFF);
    send_packet(8'h08, 8'h80, 8'h7F);
    send_packet(8'h0B, 8'h7F, 8'h80);
    send_byte(taken_status(), 8'h0C);
    send_byte(ignored_status(), 8'h55);
    send_byte(taken_status(), 8'h00);
    send_byte(taken_status(), 8'h00);
    send_packet(8'hF7, 8'h01, 8'h01);
    send_byte(8'hFF, 8'hFF);
    send_byte(8'hFF, 8'h7F);
    send_byte(8'hFF, 8'h80);
    send_packet(8'h08, 8'hFF, 8'h01);
    settle();
  endtask

  // Sweep register settings, extremes included, and lower the screen under the cursor
  task automatic test_register_extremes();
    int sens_list[7]   = '{3, 0, 31, 1, 16, 2, 5};
    int width_list[7]  = '{100, 0, 8191, 4096, 1, 1024, 4096};
    int height_list[7] = '{50, 0, 5000, 4096, 1, 768, 1};
    for (int i = 0; i < 7; i++) begin
      apply_settings(DATA_W'(sens_list[i]), DATA_W'(width_list[i]), DATA_W'(height_list[i]));
      send_packet(8'h0F, 8'hFF, 8'h01);
      send_packet(8'h08, 8'h01, 8'hFF);
      repeat (3) send_packet(8'h09, 8'h7F, 8'h80);
      send_packet(8'h0A, 8'h80, 8'h7F);
      repeat (15) send_random_packet();
      settle();
    end
  endtask

  // Long random traffic under random settings; the last phase runs without idling
  task automatic test_random_traffic();
    logic [DATA_W-1:0] w;
    logic [DATA_W-1:0] h;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      idling = (phase < RANDOM_PHASES - 1);
      w = ($urandom_range(0, 3) == 0) ? DATA_W'($urandom_range(0, 8191))
                                       : DATA_W'($urandom_range(16, 1024));
      h = ($urandom_range(0, 3) == 0) ? DATA_W'($urandom_range(0, 8191))
                                       : DATA_W'($urandom_range(16, 1024));
      apply_settings(DATA_W'($urandom_range(0, 31)), w, h);
      repeat (PACKETS_PER_PHASE) send_random_packet();
      settle();
    end
  endtask

  // Receiver: stall in short random bursts while idling is on
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else if (idling && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic compare_field(input string field_name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field_name, want, got);
      error_count++;
    end
  endtask

  // Compare each report transfer against the oldest queued prediction
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_reports.size() == 0) begin
        $error("report transfer with none predicted: cursor_x %0d cursor_y %0d",
               out_ch.cursor_x, out_ch.cursor_y);
        error_count++;
      end else begin
        want_rpt = pending_reports.pop_front();
        compare_field("cursor_x", want_rpt.cursor_x, out_ch.cursor_x);
        compare_field("cursor_y", want_rpt.cursor_y, out_ch.cursor_y);
        compare_field("left_down", want_rpt.left_down, out_ch.left_down);
        compare_field("right_down", want_rpt.right_down, out_ch.right_down);
        compare_field("middle_down", want_rpt.middle_down, out_ch.middle_down);
        compare_field("left_press", want_rpt.left_press, out_ch.left_press);
        compare_field("right_press", want_rpt.right_press, out_ch.right_press);
        compare_field("left_rel", want_rpt.left_rel, out_ch.left_rel);
        compare_field("right_rel", want_rpt.right_rel, out_ch.right_rel);
      end
    end
  end

  // Watchdog: end the run if no transfer happens on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL ps2_mouse_packet_tracker");
        $finish;
      end
    end
  end

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.ctrl_status = '0;
    in_ch.data_byte   = '0;
    wr_en             = 1'b0;
    wr_index          = REG_SENSITIVITY;
    wr_data           = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_packet_basics();
    test_register_extremes();
    test_random_traffic();
    if (error_count == 0) begin
      $display("PASS ps2_mouse_packet_tracker");
    end else begin
      $display("FAIL ps2_mouse_packet_tracker");
    end
    $finish;
  end

endmodule
